// ----- src/plr_pkg.sv -----
// shared types, codes and constants of the point list
package plr_pkg;

   localparam int unsigned DEPTH_DEFAULT = 1024;

   localparam int unsigned COUNT_W = 11;
   localparam int unsigned POS_W   = 10;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned ENTRY_W = 2 * COORD_W;

   localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

   // commands
   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_POS  = 2'd2;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [COUNT_W-1:0]        count;
      logic signed [COORD_W-1:0] read_x;
      logic signed [COORD_W-1:0] read_y;
   } rsp_type;

endpackage

// ----- src/plr_ram.sv -----
// generic single-write, single-read ram with registered read data
module plr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/point_list_insert_remove_core.sv -----
// top level of the point list: command sequencer around one point ram
// append, rejected commands and a remove of the last point end in decode; read
//   goes on to the read state; insert shifts entries up from the top down to
//   position, remove shifts them down from position + 1; results wait in done
// one item at a time; shifts move one entry per cycle through the single ram port
//   pair; the next item is taken the cycle after a result is loaded to rsp
// reset is synchronous: count cleared, capacity back to 1024, ram contents kept
module point_list_insert_remove_core #(
   parameter int unsigned DEPTH = plr_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  plr_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output plr_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [plr_pkg::COUNT_W-1:0]   csr_wr_data
);

   import plr_pkg::*;

   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   // compare width, wide enough for count, capacity and position
   localparam int unsigned CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_INS    = 3'd2;
   localparam logic [2:0] S_REM    = 3'd3;
   localparam logic [2:0] S_RD     = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0] cap_ff, cap_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [1:0]         status_ff, status_in;
   logic [ENTRY_W-1:0] rpt_ff, rpt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // ram ports
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // decode helpers
   logic [CW-1:0]      cnt_w, pos_w, cap_w, limit_w, idx_w;
   logic [AW-1:0]      pos_a, cnt_a, idx_dn1, idx_dn2, idx_up1;
   logic               full;
   logic [ENTRY_W-1:0] entry;

   plr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective limit is the smaller of capacity and store depth
   assign cnt_w   = CW'(count_ff);
   assign pos_w   = CW'(req_ff.position);
   assign cap_w   = CW'(cap_ff);
   assign limit_w = (cap_w < CW'(DEPTH)) ? cap_w : CW'(DEPTH);
   assign idx_w   = CW'(idx_ff);
   assign full    = (cnt_w >= limit_w);

   // store indexes; only used where the value is known to be below DEPTH
   assign pos_a   = AW'(req_ff.position);
   assign cnt_a   = AW'(count_ff);
   assign idx_dn1 = idx_ff - AW'(1);
   assign idx_dn2 = idx_ff - AW'(2);
   assign idx_up1 = idx_ff + AW'(1);

   // x in the low half, y in the high half
   assign entry = {req_ff.point_y, req_ff.point_x};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      rpt_in       = rpt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cnt_a;
      ram_wr_data  = entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pos_a;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = ST_OK;
            rpt_in    = '0;
            state_in  = S_DONE;
            case (req_ff.command)
               CMD_APPEND: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cnt_a;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               CMD_INSERT: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else if (pos_w > cnt_w) begin
                     status_in = ST_POS;
                  end else if (pos_w == cnt_w) begin
                     // insert at the end is an append
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cnt_a;
                     count_in    = count_ff + CNT_W'(1);
                  end else begin
                     // shift up from the top, read one below the write slot
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = cnt_a - AW'(1);
                     idx_in      = cnt_a;
                     state_in    = S_INS;
                  end
               end
               CMD_REMOVE: begin
                  if (pos_w >= cnt_w) begin
                     status_in = ST_POS;
                  end else if (pos_w + CW'(1) == cnt_w) begin
                     // last entry: nothing to move
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = pos_a + AW'(1);
                     idx_in      = pos_a + AW'(1);
                     state_in    = S_REM;
                  end
               end
               default: begin
                  if (pos_w >= cnt_w) begin
                     status_in = ST_POS;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = pos_a;
                     state_in    = S_RD;
                  end
               end
            endcase
         end

         S_INS: begin
            // idx_ff is the write slot; read data is the entry just below it
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            if (idx_ff == pos_a) begin
               ram_wr_data = entry;
               count_in    = count_ff + CNT_W'(1);
               state_in    = S_DONE;
            end else begin
               ram_wr_data = ram_rd_data;
               idx_in      = idx_dn1;
               if (idx_dn1 != pos_a) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_dn2;
               end
            end
         end

         S_REM: begin
            // idx_ff is the entry whose data arrives now; it moves down one
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_dn1;
            ram_wr_data = ram_rd_data;
            if (idx_w + CW'(1) < cnt_w) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_up1;
               idx_in      = idx_up1;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_RD: begin
            rpt_in   = ram_rd_data;
            state_in = S_DONE;
         end

         S_DONE: begin
            // wait for the output slot to be free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status = status_ff;
               rsp_in.count  = cnt_w[COUNT_W-1:0];
               rsp_in.read_x = rpt_ff[COORD_W-1:0];
               rsp_in.read_y = rpt_ff[ENTRY_W-1:COORD_W];
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rpt_ff    <= rpt_in;
      rsp_ff    <= rsp_in;
   end

   // an accepted item always goes to decode next
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DECODE)
      else $error("accepted item did not enter decode");

   // the count holds while idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |=> $stable(count_ff))
      else $error("count changed while idle");

   // the store is written only while a command is being worked
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_DECODE || state_ff == S_INS || state_ff == S_REM))
      else $error("store written outside a command");

   // a new result only comes out of the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside done state");

endmodule
